### hw/rtl/ots_pkg.sv
// ots_pkg: shared types and constants for the otsu threshold search block
// no dependencies

package ots_pkg;

    localparam int HIST_DEPTH = 256;
    localparam int LEVEL_MAX  = 255;
    localparam int LEVEL_BITS = 8;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_INC,
        S_SUM,
        S_RD,
        S_ACC,
        S_P,
        S_Q,
        S_D2,
        S_DEN,
        S_LHS,
        S_RHS,
        S_OUT
    } ots_state_t;

endpackage

### hw/rtl/ots_ram.sv
// ots_ram: generic simple dual-port ram, one write port and one registered read port
// no dependencies

module ots_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/otsu_threshold_search_top.sv
// otsu_threshold_search_top: histogram and otsu threshold search over one frame
// depends on ots_pkg and ots_ram
//
// usage: one pixel word per s_ handshake (s_pixel, s_last). nonzero pixels are
// counted into a 256-bin histogram held in a ram; zero pixels are dropped.
// a zero pixel has no bin update; a nonzero pixel is a ram read, then a write.
// after the word with s_last set the block sums the histogram, then walks
// every threshold: each bin is read and accumulated, and for each bin that
// splits the frame six products run on one shared shift-add multiplier.
// the bins are zeroed during that walk. one result word
// (m_threshold, m_found, m_saturated) is then loaded into the output register.
// s_ready is low from the last pixel until the result is loaded; the next frame
// may start while that word still waits on m_ready. if a new result is due
// while the old one is not taken, the search holds until it is.
// reset: a clearing pass writes zero to all 256 bins, with s_ready low.

module otsu_threshold_search_top
    import ots_pkg::*;
#(
    parameter int COUNT_BITS = 20
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_pixel,
    input  logic       s_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_threshold,
    output logic       m_found,
    output logic       m_saturated
);

    localparam int NW   = COUNT_BITS + 8;
    localparam int SW   = COUNT_BITS + 16;
    localparam int DW   = NW + SW;
    localparam int D2W  = 2 * DW;
    localparam int DENW = 2 * NW;
    localparam int LW   = D2W + DENW;
    localparam int TPW  = COUNT_BITS + LEVEL_BITS;

    localparam logic [COUNT_BITS-1:0] MAXC = {COUNT_BITS{1'b1}};

    ots_state_t state_reg, state_next;
    logic [LEVEL_BITS:0]   cnt_reg, cnt_next;
    logic                  rv_reg, rv_next;
    logic [LEVEL_BITS-1:0] ridx_reg, ridx_next;
    logic [LEVEL_BITS-1:0] pix_reg, pix_next;
    logic                  last_reg, last_next;
    logic [NW-1:0]         ntot_reg, ntot_next, nb_reg, nb_next;
    logic [SW-1:0]         stot_reg, stot_next, sb_reg, sb_next;
    logic [DW-1:0]         p_reg, p_next;
    logic [D2W-1:0]        d2_reg, d2_next, best_d2_reg, best_d2_next;
    logic [DENW-1:0]       den_reg, den_next, best_den_reg, best_den_next;
    logic [LW-1:0]         lhs_reg, lhs_next;
    logic [LEVEL_BITS-1:0] thr_reg, thr_next;
    logic                  found_reg, found_next, sat_reg, sat_next;
    logic [LW-1:0]         ma_reg, ma_next, acc_reg, acc_next;
    logic [DW-1:0]         mb_reg, mb_next;
    logic                  m_valid_reg, m_valid_next;
    logic [7:0]            m_thr_reg, m_thr_next;
    logic                  m_found_reg, m_found_next, m_sat_reg, m_sat_next;

    logic                  ram_we;
    logic [LEVEL_BITS-1:0] ram_waddr, ram_raddr;
    logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;

    logic [TPW-1:0]        tprod;
    logic [NW-1:0]         nb_sum, nf_new, nf_cur;
    logic [SW-1:0]         sb_sum;
    logic [DW-1:0]         q_val, d_val;
    logic [COUNT_BITS-1:0] inc_val;
    logic                  mul_done, last_bin;

    ots_ram #(
        .WIDTH(COUNT_BITS),
        .DEPTH(HIST_DEPTH)
    ) u_hist (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign s_ready     = (state_reg == S_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_threshold = m_thr_reg;
    assign m_found     = m_found_reg;
    assign m_saturated = m_sat_reg;

    // bin index times bin count
    assign tprod    = TPW'(ridx_reg) * TPW'(ram_rdata);
    assign nb_sum   = nb_reg + NW'(ram_rdata);
    assign sb_sum   = sb_reg + SW'(tprod);
    assign nf_new   = ntot_reg - nb_sum;
    assign nf_cur   = ntot_reg - nb_reg;
    assign q_val    = acc_reg[DW-1:0];
    assign d_val    = (p_reg >= q_val) ? (p_reg - q_val) : (q_val - p_reg);
    assign inc_val  = (ram_rdata < MAXC) ? (ram_rdata + 1'b1) : ram_rdata;
    assign mul_done = (mb_reg == '0);
    assign last_bin = (cnt_reg[LEVEL_BITS-1:0] == LEVEL_BITS'(LEVEL_MAX));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            cnt_reg     <= '0;
            rv_reg      <= 1'b0;
            sat_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rv_reg      <= rv_next;
            sat_reg     <= sat_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ridx_reg     <= ridx_next;
        pix_reg      <= pix_next;
        last_reg     <= last_next;
        ntot_reg     <= ntot_next;
        stot_reg     <= stot_next;
        nb_reg       <= nb_next;
        sb_reg       <= sb_next;
        p_reg        <= p_next;
        d2_reg       <= d2_next;
        den_reg      <= den_next;
        lhs_reg      <= lhs_next;
        best_d2_reg  <= best_d2_next;
        best_den_reg <= best_den_next;
        thr_reg      <= thr_next;
        found_reg    <= found_next;
        ma_reg       <= ma_next;
        mb_reg       <= mb_next;
        acc_reg      <= acc_next;
        m_thr_reg    <= m_thr_next;
        m_found_reg  <= m_found_next;
        m_sat_reg    <= m_sat_next;
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        rv_next       = rv_reg;
        ridx_next     = ridx_reg;
        pix_next      = pix_reg;
        last_next     = last_reg;
        ntot_next     = ntot_reg;
        stot_next     = stot_reg;
        nb_next       = nb_reg;
        sb_next       = sb_reg;
        p_next        = p_reg;
        d2_next       = d2_reg;
        den_next      = den_reg;
        lhs_next      = lhs_reg;
        best_d2_next  = best_d2_reg;
        best_den_next = best_den_reg;
        thr_next      = thr_reg;
        found_next    = found_reg;
        sat_next      = sat_reg;
        ma_next       = ma_reg;
        mb_next       = mb_reg;
        acc_next      = acc_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_thr_next    = m_thr_reg;
        m_found_next  = m_found_reg;
        m_sat_next    = m_sat_reg;
        ram_we        = 1'b0;
        ram_waddr     = cnt_reg[LEVEL_BITS-1:0];
        ram_wdata     = '0;
        ram_raddr     = cnt_reg[LEVEL_BITS-1:0];

        // shift-add step, overridden when a product completes
        if (mb_reg[0]) begin
            acc_next = acc_reg + ma_reg;
        end
        ma_next = ma_reg << 1;
        mb_next = mb_reg >> 1;

        unique case (state_reg)
            S_CLR: begin
                ram_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (last_bin) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                ram_raddr = s_pixel;
                pix_next  = s_pixel;
                last_next = s_last;
                if (s_valid) begin
                    if (s_pixel != '0) begin
                        state_next = S_INC;
                    end else if (s_last) begin
                        state_next = S_SUM;
                    end
                end
                cnt_next      = '0;
                rv_next       = 1'b0;
                ntot_next     = '0;
                stot_next     = '0;
                best_d2_next  = '0;
                best_den_next = DENW'(1);
                thr_next      = '0;
                found_next    = 1'b0;
            end
            S_INC: begin
                ram_we    = 1'b1;
                ram_waddr = pix_reg;
                ram_wdata = inc_val;
                if (inc_val == MAXC) begin
                    sat_next = 1'b1;
                end
                state_next = last_reg ? S_SUM : S_IDLE;
            end
            S_SUM: begin
                rv_next   = !cnt_reg[LEVEL_BITS];
                ridx_next = cnt_reg[LEVEL_BITS-1:0];
                if (!cnt_reg[LEVEL_BITS]) begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (rv_reg) begin
                    ntot_next = ntot_reg + NW'(ram_rdata);
                    stot_next = stot_reg + SW'(tprod);
                end
                if (cnt_reg[LEVEL_BITS] && !rv_reg) begin
                    state_next = S_RD;
                    cnt_next   = '0;
                    nb_next    = '0;
                    sb_next    = '0;
                end
            end
            S_RD: begin
                ridx_next  = cnt_reg[LEVEL_BITS-1:0];
                state_next = S_ACC;
            end
            S_ACC: begin
                ram_we  = 1'b1;
                nb_next = nb_sum;
                sb_next = sb_sum;
                if (nb_sum == '0 || nf_new == '0) begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = last_bin ? S_OUT : S_RD;
                end else begin
                    acc_next   = '0;
                    ma_next    = LW'(stot_reg - sb_sum);
                    mb_next    = DW'(nb_sum);
                    state_next = S_P;
                end
            end
            S_P: begin
                if (mul_done) begin
                    p_next     = acc_reg[DW-1:0];
                    acc_next   = '0;
                    ma_next    = LW'(nf_cur);
                    mb_next    = DW'(sb_reg);
                    state_next = S_Q;
                end
            end
            S_Q: begin
                if (mul_done) begin
                    acc_next   = '0;
                    ma_next    = LW'(d_val);
                    mb_next    = d_val;
                    state_next = S_D2;
                end
            end
            S_D2: begin
                if (mul_done) begin
                    d2_next    = acc_reg[D2W-1:0];
                    acc_next   = '0;
                    ma_next    = LW'(nb_reg);
                    mb_next    = DW'(nf_cur);
                    state_next = S_DEN;
                end
            end
            S_DEN: begin
                if (mul_done) begin
                    den_next   = acc_reg[DENW-1:0];
                    acc_next   = '0;
                    ma_next    = LW'(d2_reg);
                    mb_next    = DW'(best_den_reg);
                    state_next = S_LHS;
                end
            end
            S_LHS: begin
                if (mul_done) begin
                    lhs_next   = acc_reg;
                    acc_next   = '0;
                    ma_next    = LW'(best_d2_reg);
                    mb_next    = DW'(den_reg);
                    state_next = S_RHS;
                end
            end
            S_RHS: begin
                if (mul_done) begin
                    if (lhs_reg > acc_reg) begin
                        best_d2_next  = d2_reg;
                        best_den_next = den_reg;
                        thr_next      = cnt_reg[LEVEL_BITS-1:0];
                        found_next    = 1'b1;
                    end
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = last_bin ? S_OUT : S_RD;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_thr_next   = thr_reg;
                    m_found_next = found_reg;
                    m_sat_next   = sat_reg;
                    sat_next     = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLR;
            end
        endcase
    end

endmodule

### hw/rtl/ots_checker.sv
// ots_checker: port-level checks for the otsu threshold search block
// depends on otsu_threshold_search_top, attached by bind

module ots_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_pixel,
    input logic       s_last,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_threshold,
    input logic       m_found,
    input logic       m_saturated
);

    // result word holds while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_threshold)
            && $stable(m_found) && $stable(m_saturated))
        else $error("result word changed while stalled");

    // clearing pass follows reset
    a_reset_busy: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("ready during histogram clear");

    // a counted pixel holds s_ready low for its bin update
    a_pix_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_pixel != 8'd0) |=> !s_ready)
        else $error("ready during bin update");

    // last pixel starts the search
    a_last_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last |=> !s_ready)
        else $error("ready after last pixel");

    // no split means threshold zero
    a_no_split: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_threshold == 8'd0)
        else $error("threshold nonzero without a split");

endmodule

bind otsu_threshold_search_top ots_checker u_ots_checker (.*);

### sim/testbench.sv
// testbench: self-checking bench for otsu_threshold_search_top
// holds a scoreboard class with its own histogram and exact otsu search
// depends on the rtl of otsu_threshold_search_top, and through it on ots_pkg

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CNT_BITS = 20;
    localparam longint unsigned BIN_MAX = (64'd1 << CNT_BITS) - 1;

    typedef struct {
        logic [7:0] threshold;
        logic       found;
        logic       saturated;
    } otsu_result_t;

    class otsu_scoreboard;
        longint unsigned hist_bins[256];
        bit              sat_seen;
        otsu_result_t    expected_q[$];
        int              errors;

        function void clear_frame();
            foreach (hist_bins[i]) hist_bins[i] = 0;
            sat_seen = 0;
        endfunction

        function otsu_result_t search_threshold();
            logic [255:0] ntot, stot, nb, sb, nf, sf, p, q, d, d2, den, best_d2, best_den;
            otsu_result_t r;
            ntot = 0;
            stot = 0;
            nb = 0;
            sb = 0;
            best_d2 = 0;
            best_den = 1;
            r.threshold = 0;
            r.found = 0;
            r.saturated = sat_seen;
            for (int t = 0; t < 256; t++) begin
                ntot += hist_bins[t];
                stot += hist_bins[t] * t;
            end
            for (int t = 0; t < 256; t++) begin
                nb += hist_bins[t];
                sb += hist_bins[t] * t;
                nf = ntot - nb;
                sf = stot - sb;
                if (nb == 0 || nf == 0) continue;
                p = nb * sf;
                q = nf * sb;
                d = (p >= q) ? p - q : q - p;
                d2 = d * d;
                den = nb * nf;
                if (d2 * best_den > best_d2 * den) begin
                    best_d2 = d2;
                    best_den = den;
                    r.threshold = t[7:0];
                    r.found = 1;
                end
            end
            return r;
        endfunction

        function void note_pixel(logic [7:0] px, logic last);
            if (px != 0) begin
                if (hist_bins[px] < BIN_MAX) hist_bins[px]++;
                if (hist_bins[px] >= BIN_MAX) sat_seen = 1;
            end
            if (last) begin
                expected_q.push_back(search_threshold());
                clear_frame();
            end
        endfunction

        function void check_result(logic [7:0] thr, logic fnd, logic sat);
            otsu_result_t e;
            if (expected_q.size() == 0) begin
                $error("result word with nothing expected: threshold %0d", thr);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (thr !== e.threshold) begin
                $error("threshold: expected %0d, got %0d", e.threshold, thr);
                errors++;
            end
            if (fnd !== e.found) begin
                $error("found: expected %0d, got %0d", e.found, fnd);
                errors++;
            end
            if (sat !== e.saturated) begin
                $error("saturated: expected %0d, got %0d", e.saturated, sat);
                errors++;
            end
        endfunction
    endclass

    logic       aclk = 0;
    logic       aresetn = 0;
    logic       s_valid = 0;
    logic       s_ready;
    logic [7:0] s_pixel = 0;
    logic       s_last = 0;
    logic       m_valid;
    logic       m_ready = 0;
    logic [7:0] m_threshold;
    logic       m_found;
    logic       m_saturated;

    otsu_scoreboard sb = new();
    int  burst_left = 0;
    int  gap_pct = 30;
    bit  hold_req = 0;

    otsu_threshold_search_top #(.COUNT_BITS(CNT_BITS)) u_top (.*);

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    initial begin
        sb.clear_frame();
        #1000000000;
        $display("FAILURE");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_threshold, m_found, m_saturated);
    end

    // receiver: stall pattern changes phase, with one long hold on request
    initial begin
        int phase_left;
        int stall_pct;
        phase_left = 0;
        stall_pct = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 0;
                repeat (40000) @(negedge aclk);
                hold_req = 0;
            end
            if (phase_left == 0) begin
                phase_left = $urandom_range(50, 400);
                case ($urandom_range(2))
                    0: stall_pct = 0;
                    1: stall_pct = 30;
                    default: stall_pct = 80;
                endcase
            end
            phase_left--;
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_word(logic [7:0] px, logic last);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(99) < gap_pct) begin
                s_valid <= 0;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1;
        s_pixel <= px;
        s_last <= last;
        do @(posedge aclk); while (!s_ready);
        sb.note_pixel(px, last);
        @(negedge aclk);
    endtask

    task automatic send_frame(int len, int lo, int hi, int zero_pct);
        logic [7:0] px;
        for (int i = 0; i < len; i++) begin
            px = ($urandom_range(99) < zero_pct) ? 8'd0 : 8'($urandom_range(lo, hi));
            send_word(px, i == len - 1);
        end
    endtask

    task automatic drain_results();
        s_valid <= 0;
        while (sb.expected_q.size() != 0) @(negedge aclk);
    endtask

    initial begin
        int items;
        int lo;
        int span;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed frames
        send_word(8'd255, 1);
        send_word(8'd0, 1);
        send_word(8'd1, 0);
        send_word(8'd255, 1);
        send_word(8'd0, 0);
        send_word(8'd0, 0);
        send_word(8'd0, 1);
        send_word(8'd9, 0);
        send_word(8'd9, 0);
        send_word(8'd9, 1);
        send_word(8'd10, 0);
        send_word(8'd20, 0);
        send_word(8'd30, 0);
        send_word(8'd0, 0);
        send_word(8'd40, 1);
        send_word(8'd1, 0);
        send_word(8'd2, 0);
        send_word(8'd254, 0);
        send_word(8'd255, 0);
        send_word(8'd170, 0);
        send_word(8'd85, 1);
        send_word(8'd128, 0);
        send_word(8'd127, 1);
        drain_results();

        items = 0;
        while (items < 1400) begin
            case ($urandom_range(9))
                0: gap_pct = 0;
                1, 2: gap_pct = 80;
                default: gap_pct = 30;
            endcase
            if (items > 500 && items < 540) hold_req = 1;
            lo = $urandom_range(1, 255);
            case ($urandom_range(9))
                0: span = 255;
                1: span = 0;
                default: span = $urandom_range(1, 12);
            endcase
            if (lo + span > 255) lo = 255 - span;
            if (lo < 1) lo = 1;
            span = $urandom_range(1, 30);
            send_frame(span, lo, (lo + span > 255) ? 255 : lo + $urandom_range(0, span),
                       $urandom_range(3) == 0 ? 100 : $urandom_range(0, 40));
            items += span;
            if ($urandom_range(19) == 0) drain_results();
        end
        drain_results();
        repeat (200) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
